// ===== src/rgpc_pkg.sv =====
// types, constants and the divider step shared by the radial gradient pixel pipeline
package rgpc_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_RECT_WIDTH  = 3'd0;
   localparam logic [2:0] REG_RECT_HEIGHT = 3'd1;
   localparam logic [2:0] REG_CENTERED    = 3'd2;
   localparam logic [2:0] REG_INNER_COLOR = 3'd3;
   localparam logic [2:0] REG_OUTER_COLOR = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // field widths
   localparam int DIM_W   = 13;
   localparam int POS_X_W = 13;
   localparam int POS_Y_W = 12;
   localparam int CH_W    = 8;
   localparam int NUM_CH  = 3;
   localparam int COLOR_W = NUM_CH * CH_W;

   // largest usable rectangle side, wider settings saturate to this
   localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

   // internal widths
   localparam int DELTA_W = 14;              // signed pixel offset from the center
   localparam int DX2_W   = 27;              // square of the column offset
   localparam int DY2_W   = 24;              // square of the row offset
   localparam int R2_W    = 25;              // square of the radius, at most 2**24
   localparam int M_W     = R2_W;            // positive margin never exceeds r2
   localparam int MSUM_W  = 29;              // signed margin before the range check
   localparam int REM_W   = R2_W + CH_W;     // |inner-outer| * m
   localparam int DIV_STAGES = 4;            // two quotient bits per stage

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [DIM_W-1:0]          radius;
   } front_type;

   typedef struct packed {
      logic [DX2_W-1:0] dx2;
      logic [DY2_W-1:0] dy2;
      logic [R2_W-1:0]  r2;
   } square_type;

   typedef struct packed {
      logic [M_W-1:0]  m;
      logic [R2_W-1:0] r2;
      logic            in_circle;
   } margin_type;

   typedef struct packed {
      logic [NUM_CH-1:0][REM_W-1:0] rem;
      logic [NUM_CH-1:0][CH_W-1:0]  quo;
      logic [NUM_CH-1:0]            neg;
      logic [R2_W-1:0]              r2;
      logic                         in_circle;
   } div_type;

   // two restoring division steps for every channel, quotient bits top and top-1
   function automatic div_type div_pair(input div_type d, input int unsigned top);
      div_type          r;
      logic [REM_W-1:0] trial;
      int unsigned      b;
      r = d;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int j = 0; j < 2; j++) begin
            b     = top - j;
            trial = REM_W'(d.r2) << b;
            if (r.rem[ch] >= trial) begin
               r.rem[ch] = r.rem[ch] - trial;
               r.quo[ch] = r.quo[ch] | (CH_W'(1) << b);
            end
         end
      end
      return r;
   endfunction

endpackage

// ===== src/radial_gradient_pixel_color.sv =====
// Radial gradient pixel color generator. One pixel coordinate enters per clock and one
// color leaves per clock when nothing stalls; the pipeline runs through the squaring
// multipliers, the per-channel product and a four-stage divider that resolves two
// quotient bits per stage. Each stage holds a valid bit and only stalls when the stage after
// it is full and blocked, so bubbles close up behind a stalled result. The radius is
// min(width, height) with both sides saturated to 4096, halved in centered mode, and each
// channel is outer + (inner - outer) * m / r^2 truncated toward zero, where m is r^2 minus
// the squared distance; pixels with m <= 0 get the outer color. Size and centered settings
// take effect for pixels entering after the write, the colors also for pixels in flight.
// Configuration registers must only change while the pipeline is empty.
module radial_gradient_pixel_color (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_wen,
   input  logic [rgpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rgpc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // pixel requests
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rgpc_pkg::POS_X_W-1:0]       req_pos_x,
   input  logic [rgpc_pkg::POS_Y_W-1:0]       req_pos_y,
   // color responses
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rgpc_pkg::CH_W-1:0]          rsp_red,
   output logic [rgpc_pkg::CH_W-1:0]          rsp_green,
   output logic [rgpc_pkg::CH_W-1:0]          rsp_blue
);
   import rgpc_pkg::*;

   localparam int NUM_STAGES = 5 + DIV_STAGES;
   localparam int DIV_FIRST  = 3;

   // configuration registers
   logic [DIM_W-1:0]   rect_width_ff;
   logic [DIM_W-1:0]   rect_height_ff;
   logic               centered_ff;
   logic [COLOR_W-1:0] inner_color_ff;
   logic [COLOR_W-1:0] outer_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_width_ff  <= '0;
         rect_height_ff <= '0;
         centered_ff    <= 1'b1;
         inner_color_ff <= '0;
         outer_color_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            REG_RECT_WIDTH:  rect_width_ff  <= csr_wdata[DIM_W-1:0];
            REG_RECT_HEIGHT: rect_height_ff <= csr_wdata[DIM_W-1:0];
            REG_CENTERED:    centered_ff    <= csr_wdata[0];
            REG_INNER_COLOR: inner_color_ff <= csr_wdata[COLOR_W-1:0];
            REG_OUTER_COLOR: outer_color_ff <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valid bits and per-stage advance
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] adv;

   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in = valid_ff;
      if (adv[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (adv[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !adv[0];

   // stage 0: saturate sides, pick radius and center, offsets from the center
   front_type        front_ff;
   front_type        front_in;
   logic [DIM_W-1:0] w_sat;
   logic [DIM_W-1:0] h_sat;
   logic [DIM_W-1:0] min_side;
   logic [DIM_W-1:0] cx;
   logic [DIM_W-1:0] cy;

   always_comb begin
      w_sat    = (rect_width_ff > MAX_DIM) ? MAX_DIM : rect_width_ff;
      h_sat    = (rect_height_ff > MAX_DIM) ? MAX_DIM : rect_height_ff;
      min_side = (w_sat < h_sat) ? w_sat : h_sat;
      cx       = centered_ff ? (w_sat >> 1) : '0;
      cy       = centered_ff ? (h_sat >> 1) : '0;
      front_in.radius = centered_ff ? (min_side >> 1) : min_side;
      front_in.dx = $signed({1'b0, req_pos_x}) - $signed({1'b0, cx});
      front_in.dy = $signed({2'b0, req_pos_y}) - $signed({1'b0, cy});
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         front_ff <= front_in;
      end
   end

   // stage 1: squares of the offsets and of the radius
   square_type                square_ff;
   square_type                square_in;
   logic signed [2*DELTA_W-1:0] dx_sq;
   logic signed [2*DELTA_W-1:0] dy_sq;
   logic [2*DIM_W-1:0]          r_sq;

   always_comb begin
      dx_sq = (2*DELTA_W)'(front_ff.dx) * (2*DELTA_W)'(front_ff.dx);
      dy_sq = (2*DELTA_W)'(front_ff.dy) * (2*DELTA_W)'(front_ff.dy);
      r_sq  = (2*DIM_W)'(front_ff.radius) * (2*DIM_W)'(front_ff.radius);
      square_in.dx2 = dx_sq[DX2_W-1:0];
      square_in.dy2 = dy_sq[DY2_W-1:0];
      square_in.r2  = r_sq[R2_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         square_ff <= square_in;
      end
   end

   // stage 2: margin inside the circle
   margin_type               margin_ff;
   margin_type               margin_in;
   logic signed [MSUM_W-1:0] m_full;

   always_comb begin
      m_full = $signed({4'b0, square_ff.r2}) - $signed({2'b0, square_ff.dx2})
             - $signed({5'b0, square_ff.dy2});
      margin_in.in_circle = !m_full[MSUM_W-1] && (m_full != '0);
      margin_in.m         = m_full[M_W-1:0];
      margin_in.r2        = square_ff.r2;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         margin_ff <= margin_in;
      end
   end

   // stage 3: color difference times margin, the dividend of each channel
   div_type div_ff [DIV_STAGES+1];
   div_type div_start;

   always_comb begin
      logic [CH_W-1:0] ic;
      logic [CH_W-1:0] oc;
      logic [CH_W-1:0] mag;
      div_start.r2        = margin_ff.r2;
      div_start.in_circle = margin_ff.in_circle;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         ic  = inner_color_ff[ch*CH_W +: CH_W];
         oc  = outer_color_ff[ch*CH_W +: CH_W];
         mag = (ic < oc) ? (oc - ic) : (ic - oc);
         div_start.neg[ch] = ic < oc;
         div_start.quo[ch] = '0;
         div_start.rem[ch] = REM_W'(mag) * REM_W'(margin_ff.m);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[DIV_FIRST]) begin
         div_ff[0] <= div_start;
      end
   end

   // stages 4 to 7: restoring division by r2, two quotient bits a stage
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv[DIV_FIRST+1+k]) begin
            div_ff[k+1] <= div_pair(div_ff[k], CH_W - 1 - 2 * k);
         end
      end
   end

   // final stage: apply the signed step to the outer color, or pass the outer color outside the circle
   logic [NUM_CH-1:0][CH_W-1:0] color_ff;
   logic [NUM_CH-1:0][CH_W-1:0] color_in;

   always_comb begin
      logic [CH_W-1:0] oc;
      logic [CH_W-1:0] q;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         oc = outer_color_ff[ch*CH_W +: CH_W];
         q  = div_ff[DIV_STAGES].quo[ch];
         if (!div_ff[DIV_STAGES].in_circle) begin
            color_in[ch] = oc;
         end else if (div_ff[DIV_STAGES].neg[ch]) begin
            color_in[ch] = oc - q;
         end else begin
            color_in[ch] = oc + q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NUM_STAGES-1]) begin
         color_ff <= color_in;
      end
   end

   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign rsp_red   = color_ff[0];
   assign rsp_green = color_ff[1];
   assign rsp_blue  = color_ff[2];

   // an accepted transaction always lands in the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   // a positive margin never exceeds r2, so the quotient fits eight bits
   a_margin_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && margin_ff.in_circle |-> margin_ff.m <= margin_ff.r2)
      else $error("margin larger than r2");

   // division leaves remainders below the divisor
   a_rem_below_r2: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES-2] && div_ff[DIV_STAGES].in_circle |->
         div_ff[DIV_STAGES].rem[0] < REM_W'(div_ff[DIV_STAGES].r2) &&
         div_ff[DIV_STAGES].rem[1] < REM_W'(div_ff[DIV_STAGES].r2) &&
         div_ff[DIV_STAGES].rem[2] < REM_W'(div_ff[DIV_STAGES].r2))
      else $error("division remainder not below r2");

   // the step toward the inner color never wraps the red channel
   a_red_no_wrap: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES-2] && div_ff[DIV_STAGES].in_circle |->
         (div_ff[DIV_STAGES].neg[0] ?
            (div_ff[DIV_STAGES].quo[0] <= outer_color_ff[CH_W-1:0]) :
            ({1'b0, outer_color_ff[CH_W-1:0]} + {1'b0, div_ff[DIV_STAGES].quo[0]}
               <= (CH_W+1)'(255))))
      else $error("red channel step wrapped");

   // reset empties every stage
   a_reset_clears: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("pipeline not empty after reset");

endmodule
